// ----- rtl/core/mgcs_pkg.sv -----
// -----------------------------------------------------------------------------
// mgcs_pkg
// Types and constants shared by the staggered-grid cell stencil block.
// -----------------------------------------------------------------------------
package mgcs_pkg;

   localparam int VALUE_BITS   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int POS_BITS     = 6;
   localparam int CELL_BITS    = 6;
   localparam int INV_BITS     = 32;
   localparam int DIFF_BITS    = VALUE_BITS + 1;
   localparam int PROD_BITS    = DIFF_BITS + INV_BITS;
   localparam int ACC_BITS     = PROD_BITS - FRAC_BITS + 3;
   localparam int READ_STEPS   = 10;
   localparam int PAIRS        = READ_STEPS / 2;
   localparam int MUL_STEPS    = 3;
   localparam int FLUSH_CYCLES = 2;
   localparam int STEP_BITS    = 4;
   localparam int LANES        = 3;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic       KIND_WRITE = 1'b0;
   localparam logic       KIND_QUERY = 1'b1;
   localparam logic [1:0] COMP_U     = 2'd0;
   localparam logic [1:0] COMP_V     = 2'd1;
   localparam logic [1:0] COMP_W     = 2'd2;

   localparam logic [1:0] TERM_DIV   = 2'd0;
   localparam logic [1:0] TERM_CURL_A = 2'd1;
   localparam logic [1:0] TERM_CURL_B = 2'd2;

   typedef enum logic [2:0] {
      REG_CELLS_X = 3'd0,
      REG_CELLS_Y = 3'd1,
      REG_CELLS_Z = 3'd2,
      REG_INV_X   = 3'd3,
      REG_INV_Y   = 3'd4,
      REG_INV_Z   = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SETTLE,
      ST_MULT,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [0:0]                   kind;
      logic [1:0]                   component;
      logic [POS_BITS-1:0]          pos_x;
      logic [POS_BITS-1:0]          pos_y;
      logic [POS_BITS-1:0]          pos_z;
      logic signed [VALUE_BITS-1:0] face_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] center_u;
      logic signed [VALUE_BITS-1:0] center_v;
      logic signed [VALUE_BITS-1:0] center_w;
      logic signed [VALUE_BITS-1:0] div_value;
      logic signed [VALUE_BITS-1:0] curl_x;
      logic signed [VALUE_BITS-1:0] curl_y;
      logic signed [VALUE_BITS-1:0] curl_z;
      logic [0:0]                   bad_index;
   } rsp_type;

   typedef struct packed {
      logic [CELL_BITS-1:0] cells_x;
      logic [CELL_BITS-1:0] cells_y;
      logic [CELL_BITS-1:0] cells_z;
      logic [INV_BITS-1:0]  inv_spacing_x;
      logic [INV_BITS-1:0]  inv_spacing_y;
      logic [INV_BITS-1:0]  inv_spacing_z;
   } cfg_type;

   typedef struct packed {
      logic                 take;
      logic                 start;
      logic                 rd_vld;
      logic [STEP_BITS-1:0] rd_step;
      logic                 mul_vld;
      logic [1:0]           mul_step;
      logic                 emit;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic query_ok;
      logic out_blocked;
   } status_type;

endpackage

// ----- rtl/core/mgcs_ram.sv -----
// -----------------------------------------------------------------------------
// mgcs_ram
// Single-port RAM with registered read data.
// -----------------------------------------------------------------------------
module mgcs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/mgcs_ctrl.sv -----
// -----------------------------------------------------------------------------
// mgcs_ctrl
// Sequencer: read slots, multiply slots, flush and result hand-off.
// -----------------------------------------------------------------------------
module mgcs_ctrl
   import mgcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall
);

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && status.is_query) begin
               cmd.start = 1'b1;
               cnt_in    = '0;
               state_in  = status.query_ok ? ST_READ : ST_EMIT;
            end
         end
         ST_READ: begin
            cmd.rd_vld  = 1'b1;
            cmd.rd_step = cnt_ff;
            if (cnt_ff == STEP_BITS'(READ_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SETTLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SETTLE: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            cmd.mul_vld  = 1'b1;
            cmd.mul_step = cnt_ff[1:0];
            if (cnt_ff == STEP_BITS'(MUL_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_FLUSH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (cnt_ff == STEP_BITS'(FLUSH_CYCLES - 1)) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!status.out_blocked) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ----- rtl/core/mgcs_dp.sv -----
// -----------------------------------------------------------------------------
// mgcs_dp
// Face memories, stencil address generation, center and difference
// registers, three multiply lanes, accumulators and the result register.
// -----------------------------------------------------------------------------
module mgcs_dp
   import mgcs_pkg::*;
#(
   parameter int MAX_CELLS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int DEPTH = (MAX_CELLS + 1) * MAX_CELLS * MAX_CELLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_CELLS + 1);
   localparam int NW    = ((CW > CELL_BITS) ? CW : CELL_BITS) + 1;

   typedef logic [POS_BITS-1:0]          pos_type;
   typedef logic signed [VALUE_BITS-1:0] val_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [ACC_BITS-1:0]   acc_type;

   function automatic logic [NW-1:0] eff_cells(input logic [CELL_BITS-1:0] c);
      logic [NW-1:0] e;
      e = NW'(c);
      return (e > NW'(MAX_CELLS)) ? NW'(MAX_CELLS) : e;
   endfunction

   function automatic logic [AW-1:0] addr_u(input pos_type x, input pos_type y,
                                            input pos_type z);
      return (AW'(z) * AW'(MAX_CELLS) + AW'(y)) * AW'(MAX_CELLS + 1) + AW'(x);
   endfunction

   function automatic logic [AW-1:0] addr_v(input pos_type x, input pos_type y,
                                            input pos_type z);
      return (AW'(z) * AW'(MAX_CELLS + 1) + AW'(y)) * AW'(MAX_CELLS) + AW'(x);
   endfunction

   function automatic logic [AW-1:0] addr_w(input pos_type x, input pos_type y,
                                            input pos_type z);
      return (AW'(z) * AW'(MAX_CELLS) + AW'(y)) * AW'(MAX_CELLS) + AW'(x);
   endfunction

   function automatic diff_type sub(input val_type a, input val_type b);
      return {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
   endfunction

   function automatic val_type half_sum(input val_type a, input val_type b);
      diff_type s;
      s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
      return s[DIFF_BITS-1:1];
   endfunction

   function automatic val_type sat(input acc_type a);
      logic all_one, all_zero;
      all_one  = &a[ACC_BITS-1:VALUE_BITS-1];
      all_zero = ~|a[ACC_BITS-1:VALUE_BITS-1];
      if (all_one || all_zero) begin
         return a[VALUE_BITS-1:0];
      end
      return a[ACC_BITS-1] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                           : {1'b0, {(VALUE_BITS-1){1'b1}}};
   endfunction

   // range checks
   logic [NW-1:0] nx, ny, nz, px, py, pz, lx, ly, lz;
   logic          query_ok, wr_ok, we_u, we_v, we_w;

   always_comb begin
      nx = eff_cells(cfg.cells_x);
      ny = eff_cells(cfg.cells_y);
      nz = eff_cells(cfg.cells_z);
      px = NW'(req_data.pos_x);
      py = NW'(req_data.pos_y);
      pz = NW'(req_data.pos_z);
      lx = nx + NW'(req_data.component == COMP_U);
      ly = ny + NW'(req_data.component == COMP_V);
      lz = nz + NW'(req_data.component == COMP_W);
      query_ok = (px < nx) && (py < ny) && (pz < nz);
      wr_ok = (req_data.component == COMP_U || req_data.component == COMP_V ||
               req_data.component == COMP_W) && (px < lx) && (py < ly) && (pz < lz);
      we_u = cmd.take && (req_data.kind == KIND_WRITE) && wr_ok &&
             (req_data.component == COMP_U);
      we_v = cmd.take && (req_data.kind == KIND_WRITE) && wr_ok &&
             (req_data.component == COMP_V);
      we_w = cmd.take && (req_data.kind == KIND_WRITE) && wr_ok &&
             (req_data.component == COMP_W);
   end

   // stencil coordinates
   pos_type i_ff, j_ff, k_ff, ip1_ff, jp1_ff, kp1_ff;
   pos_type il_ff, ir_ff, jd_ff, ju_ff, kb_ff, kf_ff;
   logic    bad_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         i_ff   <= req_data.pos_x;
         j_ff   <= req_data.pos_y;
         k_ff   <= req_data.pos_z;
         ip1_ff <= req_data.pos_x + 1'b1;
         jp1_ff <= req_data.pos_y + 1'b1;
         kp1_ff <= req_data.pos_z + 1'b1;
         il_ff  <= (req_data.pos_x == '0) ? req_data.pos_x : req_data.pos_x - 1'b1;
         jd_ff  <= (req_data.pos_y == '0) ? req_data.pos_y : req_data.pos_y - 1'b1;
         kb_ff  <= (req_data.pos_z == '0) ? req_data.pos_z : req_data.pos_z - 1'b1;
         ir_ff  <= (px + 1'b1 < nx) ? req_data.pos_x + 1'b1 : req_data.pos_x;
         ju_ff  <= (py + 1'b1 < ny) ? req_data.pos_y + 1'b1 : req_data.pos_y;
         kf_ff  <= (pz + 1'b1 < nz) ? req_data.pos_z + 1'b1 : req_data.pos_z;
         bad_ff <= !query_ok;
      end
   end

   pos_type        ux, uy, uz, vx, vy, vz, wx, wy, wz;
   logic [2:0]     pair;
   logic [AW-1:0]  addr_u_mux, addr_v_mux, addr_w_mux;

   always_comb begin
      pair = cmd.rd_step[STEP_BITS-1:1];
      ux = cmd.rd_step[0] ? ip1_ff : i_ff;
      vy = cmd.rd_step[0] ? jp1_ff : j_ff;
      wz = cmd.rd_step[0] ? kp1_ff : k_ff;
      unique case (pair)
         3'd1: begin
            uy = jd_ff; uz = k_ff;
            vx = il_ff; vz = k_ff;
            wx = il_ff; wy = j_ff;
         end
         3'd2: begin
            uy = ju_ff; uz = k_ff;
            vx = ir_ff; vz = k_ff;
            wx = ir_ff; wy = j_ff;
         end
         3'd3: begin
            uy = j_ff;  uz = kb_ff;
            vx = i_ff;  vz = kb_ff;
            wx = i_ff;  wy = jd_ff;
         end
         3'd4: begin
            uy = j_ff;  uz = kf_ff;
            vx = i_ff;  vz = kf_ff;
            wx = i_ff;  wy = ju_ff;
         end
         default: begin
            uy = j_ff;  uz = k_ff;
            vx = i_ff;  vz = k_ff;
            wx = i_ff;  wy = j_ff;
         end
      endcase
      addr_u_mux = we_u ? addr_u(req_data.pos_x, req_data.pos_y, req_data.pos_z)
                        : addr_u(ux, uy, uz);
      addr_v_mux = we_v ? addr_v(req_data.pos_x, req_data.pos_y, req_data.pos_z)
                        : addr_v(vx, vy, vz);
      addr_w_mux = we_w ? addr_w(req_data.pos_x, req_data.pos_y, req_data.pos_z)
                        : addr_w(wx, wy, wz);
   end

   logic [VALUE_BITS-1:0] rd_u, rd_v, rd_w;

   mgcs_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ram_u (
      .clock(clock), .we(we_u), .addr(addr_u_mux),
      .wdata(req_data.face_value), .rdata(rd_u)
   );

   mgcs_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ram_v (
      .clock(clock), .we(we_v), .addr(addr_v_mux),
      .wdata(req_data.face_value), .rdata(rd_v)
   );

   mgcs_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ram_w (
      .clock(clock), .we(we_w), .addr(addr_w_mux),
      .wdata(req_data.face_value), .rdata(rd_w)
   );

   // face pairs to centers and differences
   logic                 rd_vld_ff;
   logic [STEP_BITS-1:0] rd_step_ff;
   val_type              first_u_ff, first_v_ff, first_w_ff;
   val_type              cen_u_ff [PAIRS];
   val_type              cen_v_ff [PAIRS];
   val_type              cen_w_ff [PAIRS];
   diff_type             diff_u_ff, diff_v_ff, diff_w_ff;
   logic [2:0]           rd_pair;

   assign rd_pair = rd_step_ff[STEP_BITS-1:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_vld;
      end
      rd_step_ff <= cmd.rd_step;
      if (rd_vld_ff) begin
         if (!rd_step_ff[0]) begin
            first_u_ff <= rd_u;
            first_v_ff <= rd_v;
            first_w_ff <= rd_w;
         end else begin
            cen_u_ff[rd_pair] <= half_sum(first_u_ff, rd_u);
            cen_v_ff[rd_pair] <= half_sum(first_v_ff, rd_v);
            cen_w_ff[rd_pair] <= half_sum(first_w_ff, rd_w);
            if (rd_pair == 3'd0) begin
               diff_u_ff <= sub(rd_u, first_u_ff);
               diff_v_ff <= sub(rd_v, first_v_ff);
               diff_w_ff <= sub(rd_w, first_w_ff);
            end
         end
      end
   end

   // multiply lanes: x, y, z spacing
   diff_type               lane_d   [LANES];
   logic [INV_BITS-1:0]    lane_inv [LANES];
   logic [DIFF_BITS-1:0]   mag_ff   [LANES];
   logic                   neg_ff   [LANES];
   logic [PROD_BITS-1:0]   prod_ff  [LANES];
   logic                   neg2_ff  [LANES];
   logic                   s1_vld_ff, s2_vld_ff;
   logic [1:0]             s1_tag_ff, s2_tag_ff;
   acc_type                term     [LANES];

   always_comb begin
      lane_inv[0] = cfg.inv_spacing_x;
      lane_inv[1] = cfg.inv_spacing_y;
      lane_inv[2] = cfg.inv_spacing_z;
      unique case (cmd.mul_step)
         TERM_DIV: begin
            lane_d[0] = diff_u_ff;
            lane_d[1] = diff_v_ff;
            lane_d[2] = diff_w_ff;
         end
         TERM_CURL_A: begin
            lane_d[0] = sub(cen_w_ff[2], cen_w_ff[1]);
            lane_d[1] = sub(cen_w_ff[4], cen_w_ff[3]);
            lane_d[2] = sub(cen_v_ff[4], cen_v_ff[3]);
         end
         default: begin
            lane_d[0] = sub(cen_v_ff[2], cen_v_ff[1]);
            lane_d[1] = sub(cen_u_ff[2], cen_u_ff[1]);
            lane_d[2] = sub(cen_u_ff[4], cen_u_ff[3]);
         end
      endcase
      for (int l = 0; l < LANES; l++) begin
         term[l] = (s2_tag_ff == TERM_DIV) ? acc_type'(prod_ff[l] >> FRAC_BITS)
                                           : acc_type'(prod_ff[l] >> (FRAC_BITS + 1));
         if (neg2_ff[l]) begin
            term[l] = -term[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.mul_vld;
         s2_vld_ff <= s1_vld_ff;
      end
      s1_tag_ff <= cmd.mul_step;
      s2_tag_ff <= s1_tag_ff;
      for (int l = 0; l < LANES; l++) begin
         neg_ff[l]  <= lane_d[l][DIFF_BITS-1];
         mag_ff[l]  <= lane_d[l][DIFF_BITS-1] ? DIFF_BITS'(-lane_d[l])
                                              : DIFF_BITS'(lane_d[l]);
         prod_ff[l] <= PROD_BITS'(mag_ff[l]) * PROD_BITS'(lane_inv[l]);
         neg2_ff[l] <= neg_ff[l];
      end
   end

   // accumulators
   acc_type div_ff, cx_ff, cy_ff, cz_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         div_ff <= '0;
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= '0;
      end else if (s2_vld_ff) begin
         unique case (s2_tag_ff)
            TERM_DIV: begin
               div_ff <= div_ff + term[0] + term[1] + term[2];
            end
            TERM_CURL_A: begin
               cy_ff <= cy_ff - term[0];
               cx_ff <= cx_ff + term[1] - term[2];
            end
            default: begin
               cz_ff <= cz_ff + term[0] - term[1];
               cy_ff <= cy_ff + term[2];
            end
         endcase
      end
   end

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in = '0;
      if (bad_ff) begin
         rsp_data_in.bad_index = 1'b1;
      end else begin
         rsp_data_in.center_u  = cen_u_ff[0];
         rsp_data_in.center_v  = cen_v_ff[0];
         rsp_data_in.center_w  = cen_w_ff[0];
         rsp_data_in.div_value = sat(div_ff);
         rsp_data_in.curl_x    = sat(cx_ff);
         rsp_data_in.curl_y    = sat(cy_ff);
         rsp_data_in.curl_z    = sat(cz_ff);
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;
   assign status.is_query    = (req_data.kind == KIND_QUERY);
   assign status.query_ok    = query_ok;
   assign status.out_blocked = rsp_valid_ff && rsp_stall;

endmodule

// ----- rtl/core/mac_grid_cell_stencil.sv -----
// -----------------------------------------------------------------------------
// mac_grid_cell_stencil
// Staggered 3D velocity grid with cell-center velocity, divergence and curl.
// -----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_data) carries write and query
//   items. A write stores one face value; out-of-range writes are dropped.
//   A query returns one item on the rsp channel; the next item is accepted
//   in the cycle after the result is loaded. A query uses ten read slots per
//   face memory (one port each) and three multiply slots per axis lane. A
//   query outside the grid skips the read, multiply and flush steps and
//   returns bad_index. The result register lets the next item in while a
//   result waits; a stalled rsp holds its item and stops the next result
//   from loading. Reset returns the sequencer to idle, drops any pending
//   result and loads the register defaults; face contents are undefined
//   until written. Registers must be written over the APB-style port only
//   while the block is idle; the block itself does not enforce this.
// -----------------------------------------------------------------------------
module mac_grid_cell_stencil
   import mgcs_pkg::*;
#(
   parameter int MAX_CELLS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type     cfg_ff, cfg_in;
   csr_reg_type csr_idx;
   logic        csr_wr;
   cmd_type     cmd;
   status_type  status;

   assign csr_idx = csr_reg_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (csr_idx)
         REG_CELLS_X: begin
            prdata = CSR_DATA_BITS'(cfg_ff.cells_x);
            if (csr_wr) cfg_in.cells_x = pwdata[CELL_BITS-1:0];
         end
         REG_CELLS_Y: begin
            prdata = CSR_DATA_BITS'(cfg_ff.cells_y);
            if (csr_wr) cfg_in.cells_y = pwdata[CELL_BITS-1:0];
         end
         REG_CELLS_Z: begin
            prdata = CSR_DATA_BITS'(cfg_ff.cells_z);
            if (csr_wr) cfg_in.cells_z = pwdata[CELL_BITS-1:0];
         end
         REG_INV_X: begin
            prdata = cfg_ff.inv_spacing_x;
            if (csr_wr) cfg_in.inv_spacing_x = pwdata;
         end
         REG_INV_Y: begin
            prdata = cfg_ff.inv_spacing_y;
            if (csr_wr) cfg_in.inv_spacing_y = pwdata;
         end
         REG_INV_Z: begin
            prdata = cfg_ff.inv_spacing_z;
            if (csr_wr) cfg_in.inv_spacing_z = pwdata;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cells_x       <= CELL_BITS'(32);
         cfg_ff.cells_y       <= CELL_BITS'(32);
         cfg_ff.cells_z       <= CELL_BITS'(32);
         cfg_ff.inv_spacing_x <= INV_BITS'(65536);
         cfg_ff.inv_spacing_y <= INV_BITS'(65536);
         cfg_ff.inv_spacing_z <= INV_BITS'(65536);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mgcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   mgcs_dp #(.MAX_CELLS(MAX_CELLS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.kind == KIND_QUERY) |=> req_stall)
      else $error("query accepted but engine not busy");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.kind == KIND_WRITE) && !rsp_valid
      |=> !rsp_valid)
      else $error("write item produced a result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_index |->
      rsp_data.center_u == '0 && rsp_data.center_v == '0 &&
      rsp_data.center_w == '0 && rsp_data.div_value == '0 &&
      rsp_data.curl_x == '0 && rsp_data.curl_y == '0 && rsp_data.curl_z == '0)
      else $error("out-of-range result carries nonzero fields");
`endif

endmodule

// ----- tb/mac_grid_cell_stencil_tb.sv -----
// -----------------------------------------------------------------------------
// mac_grid_cell_stencil_tb
// Self-checking bench for the staggered-grid cell stencil. Each phase sets the
// grid size and spacing over the register port, writes every face inside the
// grid, then runs directed or random writes and queries. A scoreboard keeps
// its own face memories and predicts every query result, field by field.
// -----------------------------------------------------------------------------
module mac_grid_cell_stencil_tb;
   import mgcs_pkg::*;

   localparam int GRID       = 32;
   localparam int DEPTH      = (GRID + 1) * GRID * GRID;
   localparam int IDLE_LIMIT = 4000;

   class stencil_board;
      logic [31:0] faces[3][DEPTH];
      logic [5:0]  cells[3];
      logic [31:0] inv[3];
      rsp_type     pending[$];
      int          errors, writes, queries, bad_queries, results;

      function new();
         foreach (faces[c, a]) faces[c][a] = '0;
         cells = '{6'd32, 6'd32, 6'd32};
         inv   = '{32'd65536, 32'd65536, 32'd65536};
      endfunction

      function int eff(int c);
         return (c > GRID) ? GRID : c;
      endfunction

      function int addr(int c, int i, int j, int k);
         if (c == COMP_U) return (k * GRID + j) * (GRID + 1) + i;
         if (c == COMP_V) return (k * (GRID + 1) + j) * GRID + i;
         return (k * GRID + j) * GRID + i;
      endfunction

      function longint face(int c, int i, int j, int k);
         int a;
         a = addr(c, i, j, k);
         if (a >= DEPTH) return 0;
         return longint'($signed(faces[c][a]));
      endfunction

      function void center(int i, int j, int k, output longint v[3]);
         v[0] = (face(COMP_U, i, j, k) + face(COMP_U, i + 1, j, k)) >>> 1;
         v[1] = (face(COMP_V, i, j, k) + face(COMP_V, i, j + 1, k)) >>> 1;
         v[2] = (face(COMP_W, i, j, k) + face(COMP_W, i, j, k + 1)) >>> 1;
      endfunction

      function longint scale(longint d, logic [31:0] s, int sh);
         logic [63:0] mag, p;
         mag = (d < 0) ? 64'(-d) : 64'(d);
         p = (mag * {32'd0, s}) >> sh;
         return (d < 0) ? -longint'(p) : longint'(p);
      endfunction

      function logic [31:0] clip(longint v);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         return v[31:0];
      endfunction

      function void set_reg(csr_reg_type r, logic [31:0] val);
         if (r <= REG_CELLS_Z) cells[r] = val[5:0];
         else inv[r - REG_INV_X] = val;
      endfunction

      function void note_item(req_type r);
         int nx, ny, nz, i, j, k, il, ir, jd, ju, kb, kf, comp;
         longint c[3], lf[3], rt[3], dn[3], up[3], bk[3], fr[3], dv;
         rsp_type o;
         nx = eff(int'(cells[0])); ny = eff(int'(cells[1])); nz = eff(int'(cells[2]));
         i = int'(r.pos_x); j = int'(r.pos_y); k = int'(r.pos_z);
         comp = int'(r.component);
         if (r.kind == KIND_WRITE) begin
            writes++;
            if (r.component > COMP_W) return;
            if (i >= nx + (r.component == COMP_U) || j >= ny + (r.component == COMP_V) ||
                k >= nz + (r.component == COMP_W)) return;
            faces[comp][addr(comp, i, j, k)] = r.face_value;
            return;
         end
         queries++;
         o = '0;
         if (i >= nx || j >= ny || k >= nz) begin
            bad_queries++;
            o.bad_index = 1'b1;
            pending.push_back(o);
            return;
         end
         center(i, j, k, c);
         o.center_u = clip(c[0]);
         o.center_v = clip(c[1]);
         o.center_w = clip(c[2]);
         dv = scale(face(COMP_U, i + 1, j, k) - face(COMP_U, i, j, k), inv[0], FRAC_BITS)
            + scale(face(COMP_V, i, j + 1, k) - face(COMP_V, i, j, k), inv[1], FRAC_BITS)
            + scale(face(COMP_W, i, j, k + 1) - face(COMP_W, i, j, k), inv[2], FRAC_BITS);
         o.div_value = clip(dv);
         il = (i > 0) ? i - 1 : i;  ir = (i + 1 < nx) ? i + 1 : i;
         jd = (j > 0) ? j - 1 : j;  ju = (j + 1 < ny) ? j + 1 : j;
         kb = (k > 0) ? k - 1 : k;  kf = (k + 1 < nz) ? k + 1 : k;
         center(il, j, k, lf); center(ir, j, k, rt);
         center(i, jd, k, dn); center(i, ju, k, up);
         center(i, j, kb, bk); center(i, j, kf, fr);
         o.curl_x = clip(scale(up[2] - dn[2], inv[1], FRAC_BITS + 1)
                       - scale(fr[1] - bk[1], inv[2], FRAC_BITS + 1));
         o.curl_y = clip(scale(fr[0] - bk[0], inv[2], FRAC_BITS + 1)
                       - scale(rt[2] - lf[2], inv[0], FRAC_BITS + 1));
         o.curl_z = clip(scale(rt[1] - lf[1], inv[0], FRAC_BITS + 1)
                       - scale(up[0] - dn[0], inv[1], FRAC_BITS + 1));
         pending.push_back(o);
      endfunction

      function void field(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $error("%s: expected %h, got %h", name, e, a);
            errors++;
         end
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         results++;
         if (pending.size() == 0) begin
            $error("result with nothing pending: %h", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         field("center_u", e.center_u, a.center_u);
         field("center_v", e.center_v, a.center_v);
         field("center_w", e.center_w, a.center_w);
         field("div_value", e.div_value, a.div_value);
         field("curl_x", e.curl_x, a.curl_x);
         field("curl_y", e.curl_y, a.curl_y);
         field("curl_z", e.curl_z, a.curl_z);
         field("bad_index", 32'(e.bad_index), 32'(a.bad_index));
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata, prdata;

   stencil_board board;
   bit quiet, hold_long;
   int idle_cycles;

   mac_grid_cell_stencil u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !reset) board.check_result(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_stall = 1'b1;
            repeat (299) @(negedge clock);
            rsp_stall = 1'b0;
            hold_long = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   function req_type item(logic kind, logic [1:0] comp, int x, int y, int z,
                          logic [31:0] val);
      req_type r;
      r.kind = kind; r.component = comp;
      r.pos_x = POS_BITS'(x); r.pos_y = POS_BITS'(y); r.pos_z = POS_BITS'(z);
      r.face_value = val;
      return r;
   endfunction

   function logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
         3: return $signed($urandom_range(0, 2 << 16)) - (1 << 16);
         default: return $urandom;
      endcase
   endfunction

   task send(req_type r);
      int g;
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      board.note_item(r);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         g = $urandom_range(1, 10);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   task drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task reg_write(csr_reg_type r, logic [31:0] val);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = CSR_ADDR_BITS'(r) << 2; pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      board.set_reg(r, val);
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task configure(int nx, int ny, int nz, logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
      reg_write(REG_CELLS_X, nx); reg_write(REG_CELLS_Y, ny); reg_write(REG_CELLS_Z, nz);
      reg_write(REG_INV_X, ix); reg_write(REG_INV_Y, iy); reg_write(REG_INV_Z, iz);
   endtask

   task fill_faces();
      int n[3];
      n[0] = board.eff(int'(board.cells[0]));
      n[1] = board.eff(int'(board.cells[1]));
      n[2] = board.eff(int'(board.cells[2]));
      if (n[0] == 0 || n[1] == 0 || n[2] == 0) return;
      for (int c = 0; c < 3; c++)
         for (int k = 0; k < n[2] + (c == 2); k++)
            for (int j = 0; j < n[1] + (c == 1); j++)
               for (int i = 0; i < n[0] + (c == 0); i++)
                  send(item(KIND_WRITE, 2'(c), i, j, k, pick_value()));
   endtask

   task random_items(int count);
      int n[3], c, sel;
      req_type r;
      n[0] = board.eff(int'(board.cells[0]));
      n[1] = board.eff(int'(board.cells[1]));
      n[2] = board.eff(int'(board.cells[2]));
      for (int t = 0; t < count; t++) begin
         sel = $urandom_range(0, 19);
         r = item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom);
         if (n[0] != 0 && n[1] != 0 && n[2] != 0) begin
            if (sel < 8) begin
               c = $urandom_range(0, 2);
               r = item(KIND_WRITE, 2'(c), $urandom_range(0, n[0] - (c != 0)),
                        $urandom_range(0, n[1] - (c != 1)),
                        $urandom_range(0, n[2] - (c != 2)), pick_value());
            end else if (sel < 17) begin
               r.kind = KIND_QUERY;
               r.pos_x = POS_BITS'($urandom_range(0, n[0] - 1));
               r.pos_y = POS_BITS'($urandom_range(0, n[1] - 1));
               r.pos_z = POS_BITS'($urandom_range(0, n[2] - 1));
            end
         end
         send(r);
      end
   endtask

   task run_phase(int nx, int ny, int nz, logic [31:0] ix, logic [31:0] iy,
                  logic [31:0] iz, int count);
      configure(nx, ny, nz, ix, iy, iz);
      fill_faces();
      random_items(count);
      drain();
   endtask

   initial begin
      board = new();
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      quiet = 1'b0; hold_long = 1'b0; idle_cycles = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      configure(4, 3, 2, 32'hffff_ffff, 32'h0001_0000, 32'h0000_8000);
      fill_faces();
      send(item(KIND_WRITE, COMP_U, 0, 0, 0, 32'h8000_0000));
      send(item(KIND_WRITE, COMP_U, 1, 0, 0, 32'h7fff_ffff));
      send(item(KIND_WRITE, COMP_V, 0, 1, 0, 32'h8000_0000));
      send(item(KIND_WRITE, COMP_W, 0, 0, 1, 32'h7fff_ffff));
      send(item(KIND_WRITE, COMP_U, 5, 0, 0, 32'h1234_5678));
      send(item(KIND_WRITE, COMP_W, 0, 0, 3, 32'h1234_5678));
      send(item(KIND_WRITE, 2'd3, 1, 1, 1, 32'hdead_beef));
      send(item(KIND_QUERY, COMP_U, 0, 0, 0, 32'h0));
      send(item(KIND_QUERY, COMP_V, 1, 0, 0, 32'h0));
      send(item(KIND_QUERY, 2'd3, 0, 1, 1, 32'hffff_ffff));
      send(item(KIND_QUERY, COMP_W, 3, 2, 1, 32'h0));
      send(item(KIND_QUERY, COMP_U, 1, 1, 0, 32'h0));
      send(item(KIND_QUERY, COMP_U, 4, 0, 0, 32'h0));
      send(item(KIND_QUERY, COMP_U, 0, 3, 0, 32'h0));
      send(item(KIND_QUERY, COMP_U, 0, 0, 63, 32'h0));
      send(item(KIND_QUERY, COMP_U, 63, 63, 63, 32'h0));
      drain();

      run_phase(1, 1, 1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 60);
      run_phase(8, 2, 1, 32'h0, 32'h0, 32'h0, 80);
      run_phase(1, 8, 2, $urandom, $urandom, $urandom, 80);
      run_phase(2, 1, 63, $urandom, 32'h0001_0000, $urandom, 80);
      run_phase(0, 5, 5, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 40);

      configure(3, 4, 2, $urandom, $urandom, $urandom);
      fill_faces();
      hold_long = 1'b1;
      random_items(100);
      drain();

      quiet = 1'b1;
      run_phase(3, 3, 3, $urandom_range(0, 1 << 20), $urandom, 32'h0002_0000, 60);

      $display("Ran %0d writes and %0d queries (%0d outside the grid) over eight grid shapes;",
               board.writes, board.queries, board.bad_queries);
      $display("checked %0d results, %0d errors.", board.results, board.errors);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- mac_grid_cell_stencil.f -----
rtl/core/mgcs_pkg.sv
rtl/core/mgcs_ram.sv
rtl/core/mgcs_ctrl.sv
rtl/core/mgcs_dp.sv
rtl/core/mac_grid_cell_stencil.sv
tb/mac_grid_cell_stencil_tb.sv
